// ===== rtl/core/priority_inheritance_mutex_core_defines.svh =====
// assertion macros used by the checker file
`ifndef PRIORITY_INHERITANCE_MUTEX_CORE_DEFINES_SVH
`define PRIORITY_INHERITANCE_MUTEX_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define PIMX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define PIMX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pimx_pkg.sv =====
package pimx_pkg;

  // operation codes
  localparam logic [1:0] OP_LOCK    = 2'd0;
  localparam logic [1:0] OP_TRYLOCK = 2'd1;
  localparam logic [1:0] OP_UNLOCK  = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BUSY     = 3'd1;
  localparam logic [2:0] ST_DENIED   = 3'd2;
  localparam logic [2:0] ST_BLOCKED  = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] task_id;
    logic [7:0] task_prio;
  } pimx_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic       prio_set_valid;
    logic [7:0] prio_set_task;
    logic [7:0] prio_set_value;
    logic       wake_valid;
    logic [7:0] woken_id;
  } pimx_res_t;

  // per-cycle command to the waiter chain
  typedef struct packed {
    logic ins;  // park the new waiter at its sorted place
    logic pop;  // drop the head, shift everything up
  } pimx_ctl_t;

endpackage

// ===== rtl/core/pimx_cell.sv =====
// one waiter slot of the sorted chain
module pimx_cell import pimx_pkg::*; #(
  parameter int unsigned PRIO_BITS = 8,
  parameter int unsigned TASK_BITS = 8
) (
  input  logic                 clk_i,
  input  pimx_ctl_t            ctl_i,
  input  logic                 occ_i,
  input  logic [TASK_BITS-1:0] new_id_i,
  input  logic [PRIO_BITS-1:0] new_prio_i,
  input  logic                 prev_ge_i,
  input  logic [TASK_BITS-1:0] prev_id_i,
  input  logic [PRIO_BITS-1:0] prev_prio_i,
  input  logic [TASK_BITS-1:0] next_id_i,
  input  logic [PRIO_BITS-1:0] next_prio_i,
  output logic                 ge_o,
  output logic [TASK_BITS-1:0] id_o,
  output logic [PRIO_BITS-1:0] prio_o
);

  logic [TASK_BITS-1:0] id_q;
  logic [PRIO_BITS-1:0] prio_q;

  // new waiter goes ahead of this entry (newest wins ties)
  assign ge_o   = !occ_i || (prio_q <= new_prio_i);
  assign id_o   = id_q;
  assign prio_o = prio_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.ins) begin
      if (prev_ge_i) begin
        id_q   <= prev_id_i;
        prio_q <= prev_prio_i;
      end else if (ge_o) begin
        id_q   <= new_id_i;
        prio_q <= new_prio_i;
      end
    end else if (ctl_i.pop) begin
      id_q   <= next_id_i;
      prio_q <= next_prio_i;
    end
  end

endmodule

// ===== rtl/core/priority_inheritance_mutex_core.sv =====
// Priority-inheritance mutex with recursion. Pulse start with a lock, trylock or unlock
// request on req_i; busy stays low, so a request is taken on every cycle that start is
// high, one item per clock. Its result appears on res_o one cycle later, marked by a
// one-cycle result_valid_o strobe, and must be taken then: there is no way to stall it.
// Waiters are held in a chain of cells kept sorted by priority (newest first on ties),
// so the next owner is always at the head and parking or waking costs one cycle.
// The waiter store needs no clearing after reset; only the waiter count is reset.
module priority_inheritance_mutex_core import pimx_pkg::*; #(
  parameter int unsigned MAX_WAITERS = 16,
  parameter int unsigned PRIO_BITS   = 8,
  parameter int unsigned TASK_BITS   = 8,
  parameter int unsigned COUNT_MAX   = 255
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  pimx_req_t req_i,
  output logic      result_valid_o,
  output pimx_res_t res_o
);

  localparam int unsigned CNT_W  = $clog2(MAX_WAITERS + 1);
  localparam int unsigned HOLD_W = $clog2(COUNT_MAX + 1);

  // owner state
  logic                 owned_q, owned_d;
  logic [TASK_BITS-1:0] owner_q, owner_d;
  logic [PRIO_BITS-1:0] base_q, base_d;
  logic [PRIO_BITS-1:0] cur_q, cur_d;
  logic [HOLD_W-1:0]    hold_q, hold_d;
  logic [CNT_W-1:0]     count_q, count_d;

  // result register
  logic      res_valid_q;
  pimx_res_t res_q, res_d;

  // request fields cut to the configured widths
  logic                 accept;
  logic [TASK_BITS-1:0] tid;
  logic [PRIO_BITS-1:0] prio;
  logic                 full;

  // waiter chain
  pimx_ctl_t            ctl;
  logic [TASK_BITS-1:0] cell_id   [MAX_WAITERS];
  logic [PRIO_BITS-1:0] cell_prio [MAX_WAITERS];
  logic [MAX_WAITERS-1:0] cell_ge;

  assign busy   = 1'b0;  // the block never stalls
  assign accept = start && !busy;
  assign tid    = TASK_BITS'(req_i.task_id);
  assign prio   = PRIO_BITS'(req_i.task_prio);
  assign full   = (count_q == CNT_W'(MAX_WAITERS));

  for (genvar i = 0; i < MAX_WAITERS; i++) begin : g_cell
    logic                 prev_ge;
    logic [TASK_BITS-1:0] prev_id, next_id;
    logic [PRIO_BITS-1:0] prev_prio, next_prio;

    // ends of the chain: head has nothing ahead, tail pulls nothing useful
    if (i == 0) begin : g_head
      assign prev_ge   = 1'b0;
      assign prev_id   = tid;
      assign prev_prio = prio;
    end else begin : g_link
      assign prev_ge   = cell_ge[i-1];
      assign prev_id   = cell_id[i-1];
      assign prev_prio = cell_prio[i-1];
    end
    if (i == MAX_WAITERS - 1) begin : g_tail
      assign next_id   = tid;
      assign next_prio = prio;
    end else begin : g_next
      assign next_id   = cell_id[i+1];
      assign next_prio = cell_prio[i+1];
    end

    pimx_cell #(
      .PRIO_BITS (PRIO_BITS),
      .TASK_BITS (TASK_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .occ_i       (count_q > CNT_W'(i)),
      .new_id_i    (tid),
      .new_prio_i  (prio),
      .prev_ge_i   (prev_ge),
      .prev_id_i   (prev_id),
      .prev_prio_i (prev_prio),
      .next_id_i   (next_id),
      .next_prio_i (next_prio),
      .ge_o        (cell_ge[i]),
      .id_o        (cell_id[i]),
      .prio_o      (cell_prio[i])
    );
  end

  // request decode: one item per cycle
  always_comb begin
    owned_d = owned_q;
    owner_d = owner_q;
    base_d  = base_q;
    cur_d   = cur_q;
    hold_d  = hold_q;
    count_d = count_q;
    ctl     = '0;
    res_d   = '0;
    res_d.status = ST_OK;

    if (accept) begin
      case (req_i.op)
        OP_LOCK, OP_TRYLOCK: begin
          if (!owned_q) begin
            owned_d = 1'b1;
            owner_d = tid;
            base_d  = prio;
            cur_d   = prio;
            hold_d  = HOLD_W'(1);
          end else if (owner_q == tid) begin
            // recursive take
            if (hold_q >= HOLD_W'(COUNT_MAX)) begin
              res_d.status = ST_OVERFLOW;
            end else begin
              hold_d = hold_q + HOLD_W'(1);
            end
          end else begin
            // contended: boost the owner even if the request then fails
            if (prio > cur_q) begin
              cur_d                = prio;
              res_d.prio_set_valid = 1'b1;
              res_d.prio_set_task  = 8'(owner_q);
              res_d.prio_set_value = 8'(prio);
            end
            if (req_i.op == OP_TRYLOCK) begin
              res_d.status = ST_BUSY;
            end else if (full) begin
              res_d.status = ST_OVERFLOW;
            end else begin
              ctl.ins      = 1'b1;
              count_d      = count_q + CNT_W'(1);
              res_d.status = ST_BLOCKED;
            end
          end
        end
        OP_UNLOCK: begin
          if (!owned_q || owner_q != tid) begin
            res_d.status = ST_DENIED;
          end else if (hold_q > HOLD_W'(1)) begin
            hold_d = hold_q - HOLD_W'(1);
          end else begin
            // final release: old owner drops back to its base priority
            res_d.prio_set_valid = 1'b1;
            res_d.prio_set_task  = 8'(owner_q);
            res_d.prio_set_value = 8'(base_q);
            if (count_q != '0) begin
              // head of the chain is the best waiter
              owner_d          = cell_id[0];
              base_d           = cell_prio[0];
              cur_d            = cell_prio[0];
              hold_d           = HOLD_W'(1);
              ctl.pop          = 1'b1;
              count_d          = count_q - CNT_W'(1);
              res_d.wake_valid = 1'b1;
              res_d.woken_id   = 8'(cell_id[0]);
            end else begin
              owned_d = 1'b0;
              hold_d  = '0;
              cur_d   = base_q;
            end
          end
        end
        default: begin
          // unknown op: answer ok, no change
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owned_q     <= 1'b0;
      owner_q     <= '0;
      base_q      <= '0;
      cur_q       <= '0;
      hold_q      <= '0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      owned_q     <= owned_d;
      owner_q     <= owner_d;
      base_q      <= base_d;
      cur_q       <= cur_d;
      hold_q      <= hold_d;
      count_q     <= count_d;
      res_valid_q <= accept;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign result_valid_o = res_valid_q;
  assign res_o          = res_q;

endmodule

// ===== rtl/core/pimx_checker.sv =====
`include "priority_inheritance_mutex_core_defines.svh"

module pimx_checker import pimx_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start_i,
  input logic      busy_i,
  input logic      result_valid_i,
  input pimx_res_t res_i
);

  `PIMX_ASSERT_NXT(a_item_answered, start_i && !busy_i, result_valid_i, "item without result")
  `PIMX_ASSERT_NXT(a_no_spurious, !(start_i && !busy_i), !result_valid_i, "result without item")
  `PIMX_ASSERT_IMP(a_wake_restores, result_valid_i && res_i.wake_valid,
    res_i.prio_set_valid && res_i.status == ST_OK, "wake without owner restore")
  `PIMX_ASSERT_IMP(a_denied_quiet, result_valid_i && res_i.status == ST_DENIED,
    !res_i.prio_set_valid && !res_i.wake_valid, "denied unlock changed state")

endmodule

bind priority_inheritance_mutex_core pimx_checker u_pimx_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start),
  .busy_i         (busy),
  .result_valid_i (result_valid_o),
  .res_i          (res_o)
);

// ===== test/pimx_checker.sv =====
`timescale 1ns / 1ps

module pimx_scoreboard import pimx_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic      busy_i,
  input  pimx_req_t req_i,
  input  logic      result_valid_i,
  input  pimx_res_t res_i,
  output int        fail_count_o,
  output int        pending_o
);

  localparam int WAITER_SLOTS = 16;
  localparam int HOLD_LIMIT   = 255;

  // shadow of the mutex
  bit         mtx_owned;
  logic [7:0] owner_id;
  logic [7:0] base_prio;
  logic [7:0] cur_prio;
  int         hold_depth;
  logic [7:0] wait_id   [WAITER_SLOTS];
  logic [7:0] wait_prio [WAITER_SLOTS];
  int         wait_cnt;

  pimx_res_t  outcome_q [$];
  pimx_res_t  want;

  // highest priority waiter, latest one on ties
  function automatic int next_owner_slot();
    int best;
    best = 0;
    for (int i = 1; i < wait_cnt; i++) begin
      if (wait_prio[i] >= wait_prio[best]) best = i;
    end
    return best;
  endfunction

  function automatic pimx_res_t predict_outcome(pimx_req_t r);
    pimx_res_t o;
    int        k;
    o = '0;
    o.status = ST_OK;
    case (r.op)
      OP_LOCK, OP_TRYLOCK: begin
        if (!mtx_owned) begin
          mtx_owned  = 1'b1;
          owner_id   = r.task_id;
          base_prio  = r.task_prio;
          cur_prio   = r.task_prio;
          hold_depth = 1;
        end else if (owner_id == r.task_id) begin
          if (hold_depth >= HOLD_LIMIT) o.status = ST_OVERFLOW;
          else hold_depth++;
        end else begin
          // inheritance happens even when the request is refused
          if (r.task_prio > cur_prio) begin
            cur_prio = r.task_prio;
            o.prio_set_valid = 1'b1;
            o.prio_set_task  = owner_id;
            o.prio_set_value = r.task_prio;
          end
          if (r.op == OP_TRYLOCK) begin
            o.status = ST_BUSY;
          end else if (wait_cnt >= WAITER_SLOTS) begin
            o.status = ST_OVERFLOW;
          end else begin
            wait_id[wait_cnt]   = r.task_id;
            wait_prio[wait_cnt] = r.task_prio;
            wait_cnt++;
            o.status = ST_BLOCKED;
          end
        end
      end
      OP_UNLOCK: begin
        if (!mtx_owned || owner_id != r.task_id) begin
          o.status = ST_DENIED;
        end else if (hold_depth > 1) begin
          hold_depth--;
        end else begin
          o.prio_set_valid = 1'b1;
          o.prio_set_task  = owner_id;
          o.prio_set_value = base_prio;
          if (wait_cnt > 0) begin
            k = next_owner_slot();
            owner_id   = wait_id[k];
            base_prio  = wait_prio[k];
            cur_prio   = wait_prio[k];
            hold_depth = 1;
            for (int i = k; i + 1 < wait_cnt; i++) begin
              wait_id[i]   = wait_id[i + 1];
              wait_prio[i] = wait_prio[i + 1];
            end
            wait_cnt--;
            o.wake_valid = 1'b1;
            o.woken_id   = owner_id;
          end else begin
            mtx_owned  = 1'b0;
            hold_depth = 0;
            cur_prio   = base_prio;
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic check_field(string field, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t %s mismatch: expected %0d actual %0d", $time, field, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mtx_owned  = 1'b0;
      owner_id   = '0;
      base_prio  = '0;
      cur_prio   = '0;
      hold_depth = 0;
      wait_cnt   = 0;
      outcome_q.delete();
      pending_o <= 0;
    end else begin
      // results first: the item taken at this edge cannot answer yet
      if (result_valid_i === 1'b1) begin
        if (outcome_q.size() == 0) begin
          $display("%0t unexpected result: expected none actual %h", $time, res_i);
          fail_count_o++;
        end else begin
          want = outcome_q.pop_front();
          check_field("status", 8'(want.status), 8'(res_i.status));
          check_field("prio_set_valid", 8'(want.prio_set_valid), 8'(res_i.prio_set_valid));
          check_field("prio_set_task", want.prio_set_task, res_i.prio_set_task);
          check_field("prio_set_value", want.prio_set_value, res_i.prio_set_value);
          check_field("wake_valid", 8'(want.wake_valid), 8'(res_i.wake_valid));
          check_field("woken_id", want.woken_id, res_i.woken_id);
        end
      end
      if (start_i === 1'b1 && busy_i === 1'b0) outcome_q.push_back(predict_outcome(req_i));
      pending_o <= outcome_q.size();
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb import pimx_pkg::*; ();

  // the op code the block has to ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  pimx_req_t   req;
  logic        res_valid;
  pimx_res_t   res;

  int          fail_count;
  int          pending;

  // bookkeeping for steering the stimulus from what the block answers
  int unsigned sent_cnt;
  int unsigned res_cnt;
  pimx_res_t   last_res;
  int          idle_pct;

  priority_inheritance_mutex_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req),
    .result_valid_o (res_valid),
    .res_o          (res)
  );

  pimx_scoreboard u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .req_i          (req),
    .result_valid_i (res_valid),
    .res_i          (res),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // results cannot be stalled, so just count them and keep the latest one
  always @(posedge clk_i) begin
    if (res_valid === 1'b1) begin
      res_cnt  <= res_cnt + 1;
      last_res <= res;
    end
  end

  // priorities lean on the extremes now and then
  function automatic logic [7:0] rand_prio();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // offer one item, idling first at the phase's rate; start stays high on return
  task automatic send_item(pimx_req_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req   <= r;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    sent_cnt++;
  endtask

  task automatic send_op(logic [1:0] op, logic [7:0] id, logic [7:0] prio);
    pimx_req_t r;
    r = '{op: op, task_id: id, task_prio: prio};
    send_item(r);
  endtask

  // sender holds off until every item so far has answered
  task automatic wait_results();
    start <= 1'b0;
    while (res_cnt < sent_cnt) @(posedge clk_i);
  endtask

  // unlock one at a time, following each hand-over, until the mutex is free;
  // recursion is unwound by repeating the unlock while it answers plain ok
  task automatic release_all(logic [7:0] ids[$]);
    int         idx;
    int         guard;
    logic [7:0] who;
    bit         freed;
    bit         stop;
    freed = 1'b0;
    guard = 0;
    idx   = 0;
    while (!freed && idx < ids.size() && guard < 2000) begin
      who  = ids[idx];
      stop = 1'b0;
      while (!stop && guard < 2000) begin
        send_op(OP_UNLOCK, who, rand_prio());
        wait_results();
        guard++;
        if (last_res.status == ST_DENIED) begin
          stop = 1'b1;
        end else if (last_res.wake_valid) begin
          who = last_res.woken_id;
        end else if (last_res.prio_set_valid) begin
          freed = 1'b1;
          stop  = 1'b1;
        end
      end
      idx++;
    end
  endtask

  // low priority owner, then more blocking locks than the store can hold,
  // so the last ones overflow and some of them still boost the owner
  task automatic fill_store();
    logic [7:0] ids[$];
    logic [7:0] own;
    logic [7:0] t;
    own = 8'($urandom_range(0, 255));
    ids.push_back(own);
    send_op(OP_LOCK, own, 8'($urandom_range(0, 60)));
    repeat (18) begin
      t = 8'($urandom_range(0, 255));
      ids.push_back(t);
      send_op(OP_LOCK, t, rand_prio());
    end
    release_all(ids);
  endtask

  // a few tasks fight over the mutex with a mix of every op
  task automatic stir_contention(int n);
    logic [7:0] ids[$];
    logic [7:0] pool[3];
    logic [7:0] who;
    logic [1:0] op;
    int         pick;
    foreach (pool[i]) begin
      pool[i] = 8'($urandom_range(0, 255));
      ids.push_back(pool[i]);
    end
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 30)      op = OP_LOCK;
      else if (pick < 50) op = OP_TRYLOCK;
      else if (pick < 95) op = OP_UNLOCK;
      else                op = OP_UNUSED;
      if ($urandom_range(0, 9) == 0) begin
        // an outsider now and then
        who = 8'($urandom_range(0, 255));
        ids.push_back(who);
      end else begin
        who = pool[$urandom_range(0, 2)];
      end
      send_op(op, who, rand_prio());
    end
    release_all(ids);
  endtask

  // drive the recursion count up to its ceiling and past it, then park a
  // contender, then unwind all of it
  task automatic deep_recursion();
    logic [7:0] ids[$];
    logic [7:0] own;
    logic [7:0] rival;
    own   = 8'($urandom_range(0, 255));
    rival = own ^ 8'($urandom_range(1, 255));
    ids.push_back(own);
    ids.push_back(rival);
    send_op(OP_LOCK, own, 8'($urandom_range(0, 100)));
    repeat (256) begin
      send_op($urandom_range(0, 1) ? OP_TRYLOCK : OP_LOCK, own, rand_prio());
    end
    send_op(OP_LOCK, rival, 8'd255);
    send_op(OP_TRYLOCK, rival ^ 8'h80, rand_prio());
    release_all(ids);
  endtask

  initial begin
    int phase_pct[3];
    phase_pct = '{0, 54, 14};

    rst_ni   = 1'b0;
    start    = 1'b0;
    req      = '0;
    idle_pct = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // free mutex taken at the lowest id and priority, then recursion
    send_op(OP_LOCK, 8'd0, 8'd0);
    send_op(OP_LOCK, 8'd0, 8'd3);
    send_op(OP_TRYLOCK, 8'd0, 8'd0);
    // contended trylock with a boost, then one too weak to boost
    send_op(OP_TRYLOCK, 8'd255, 8'd255);
    send_op(OP_TRYLOCK, 8'd7, 8'd10);
    // unlock by someone else, and an op that is to be ignored
    send_op(OP_UNLOCK, 8'd255, 8'd255);
    send_op(OP_UNUSED, 8'd255, 8'd255);
    // unwind the recursion; the final unlock restores the base priority
    send_op(OP_UNLOCK, 8'd0, 8'd0);
    send_op(OP_UNLOCK, 8'd0, 8'd0);
    send_op(OP_UNLOCK, 8'd0, 8'd255);
    // unlock of a free mutex, then trylock of a free one
    send_op(OP_UNLOCK, 8'd0, 8'd0);
    send_op(OP_TRYLOCK, 8'd128, 8'd1);
    send_op(OP_UNLOCK, 8'd128, 8'd1);
    // parked waiters: no boost, boost, equal priorities, a duplicate
    send_op(OP_LOCK, 8'd5, 8'd100);
    send_op(OP_LOCK, 8'd6, 8'd50);
    send_op(OP_LOCK, 8'd7, 8'd200);
    send_op(OP_LOCK, 8'd8, 8'd200);
    send_op(OP_LOCK, 8'd9, 8'd200);
    send_op(OP_LOCK, 8'd6, 8'd50);
    // hand-over: ties go to the newest, the duplicate is woken twice
    send_op(OP_UNLOCK, 8'd5, 8'd200);
    send_op(OP_UNLOCK, 8'd9, 8'd200);
    send_op(OP_UNLOCK, 8'd8, 8'd200);
    send_op(OP_UNLOCK, 8'd7, 8'd200);
    send_op(OP_UNLOCK, 8'd6, 8'd50);
    send_op(OP_UNLOCK, 8'd6, 8'd50);
    wait_results();

    // random part, one pass per sender idling rate
    foreach (phase_pct[p]) begin
      idle_pct = phase_pct[p];
      fill_store();
      stir_contention(25);
      if (phase_pct[p] == 54) deep_recursion();
      stir_contention(25);
    end

    // every item has answered here; let the clock run on before the final check
    repeat (4) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("tb failed");
    $finish;
  end

endmodule
